@@ src/cosine_key_edge_fade_core_defines.svh @@
// Assertion helpers for the key-edge fade core.
// Each macro expects clk and rst_n in scope.
`ifndef COSINE_KEY_EDGE_FADE_CORE_DEFINES_SVH
`define COSINE_KEY_EDGE_FADE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CKEF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CKEF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ckef_pkg.sv @@
`default_nettype none

package ckef_pkg;

    localparam int LEN_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = 5;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 30;
    localparam int STEP_W     = 3;

    localparam logic [LEN_W-1:0]     LEN_RESET = 16'd480;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = 1'b1;

    // pi in Q30
    localparam logic [MUL_W-1:0] PI_Q30 = 32'd3373259426;
    // Q30 unity
    localparam logic [30:0] H_ONE = 31'h4000_0000;
    // innermost Horner coefficient, then the number of subtract passes
    localparam logic [ACC_W-1:0]  ACC_INIT     = 30'd2;
    localparam logic [STEP_W-1:0] HORNER_STEPS = 3'd5;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_IN   = 2'd1,
        MODE_ON   = 2'd2,
        MODE_OUT  = 2'd3
    } ramp_mode_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RMUL,
        SEQ_RLOAD,
        SEQ_RDIV,
        SEQ_REND,
        SEQ_EVAL,
        SEQ_FDIV,
        SEQ_YMUL,
        SEQ_ZMUL,
        SEQ_ZSAVE,
        SEQ_HMUL,
        SEQ_HSUB,
        SEQ_DONE
    } seq_state_t;

    // Taylor coefficients of 1-cos in Q30, outermost last
    function automatic logic [ACC_W-1:0] horner_coef(input logic [STEP_W-1:0] k);
        logic [ACC_W-1:0] c;
        case (k)
            3'd0:    c = 30'd296;
            3'd1:    c = 30'd26631;
            3'd2:    c = 30'd1491308;
            3'd3:    c = 30'd44739243;
            3'd4:    c = 30'd536870912;
            default: c = '0;
        endcase
        return c;
    endfunction

    // coefficient minus truncated product, floored at zero
    function automatic logic [ACC_W-1:0] horner_sub(input logic [STEP_W-1:0] k,
                                                    input logic [MUL_W-1:0] t);
        logic [ACC_W-1:0] c;
        c = horner_coef(k);
        if ({2'b00, c} > t)
            return c - t[ACC_W-1:0];
        else
            return '0;
    endfunction

endpackage

`default_nettype wire

@@ src/cosine_key_edge_fade_core.sv @@
// Raised-cosine key-edge gain ramp, one result beat per input beat.
// Steady beats (idle, on, snap) go straight to the output; a fading sample runs the divider and the
// Horner series, and a sample that reverses a fade first remaps its phase with a multiply and a divide.
// The input stalls from accept until the result is handed to the output register; the work is done by the
// 32-step shift-subtract divider and six Horner passes through one shared 32x32 multiplier.
// Reset (async, rst_n low): both fade lengths 480, mode idle, phase 0, key low.
`default_nettype none

module cosine_key_edge_fade_core #(
    parameter int ANGLE_BITS     = 12,
    parameter int GAIN_FRAC_BITS = 15
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          key_on,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [GAIN_FRAC_BITS:0]            gain,
    output logic [1:0]                         ramp_state,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ckef_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ckef_pkg::LEN_W-1:0]     cfg_data
);
    import ckef_pkg::*;
    `include "cosine_key_edge_fade_core_defines.svh"

    localparam int GW = GAIN_FRAC_BITS + 1;
    localparam int HW = 31 + GAIN_FRAC_BITS;
    localparam logic [GW-1:0]         UNITY      = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [ANGLE_BITS:0]   ANGLE_FULL = {1'b1, {ANGLE_BITS{1'b0}}};
    localparam logic [ANGLE_BITS:0]   ANGLE_HALF = ANGLE_FULL >> 1;
    localparam logic [HW-1:0]         ROUND_HALF = HW'(1) << 29;
    localparam logic [DIV_CNT_W-1:0]  DIV_LAST   = DIV_CNT_W'(DIV_W - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    seq_state_t             seq_reg, seq_next;
    ramp_mode_t             mode_reg, mode_next;
    logic [LEN_W-1:0]       phase_reg, phase_next;
    logic                   last_key_reg, last_key_next;
    logic [LEN_W-1:0]       fade_in_len_reg, fade_out_len_reg;

    // shift-subtract divider
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic [LEN_W-1:0]       den_reg, den_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    // shared multiplier and cosine series
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   folded_reg, folded_next;
    logic [MUL_W-1:0]       z_reg, z_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [GW-1:0]          res_gain_reg, res_gain_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [GW-1:0]          gain_reg, gain_next;
    logic [1:0]             ramp_state_reg, ramp_state_next;

    // ------------------------------------------------------------------
    // Shared datapath pieces
    // ------------------------------------------------------------------
    logic                   in_fire;
    logic                   out_free;
    logic                   key_edge;
    logic                   reversal;
    logic [LEN_W-1:0]       acc_nold;
    logic [LEN_W-1:0]       len_nold, len_nnew, len_cur;

    logic [LEN_W:0]         rem_shift;
    logic                   div_fit;
    logic [LEN_W-1:0]       rem_step;
    logic [DIV_W-1:0]       quo_step;

    logic [ANGLE_BITS-1:0]  f_val;
    logic                   f_fold;
    logic [ANGLE_BITS:0]    f_prime;
    logic [MUL_W-1:0]       y_val;
    logic [MUL_W-1:0]       t_val;

    logic [30:0]            h_raw, h_clamp, h_val;
    logic [HW-1:0]          h_sum;
    logic [GW-1:0]          gain_in;

    assign in_stall  = (seq_reg != SEQ_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign gain       = gain_reg;
    assign ramp_state = ramp_state_reg;

    // edge detection on the incoming beat, seen against the pre-step mode
    assign key_edge = (key_on != last_key_reg);
    assign reversal = key_edge && ((key_on && (mode_reg == MODE_OUT)) ||
                                   (!key_on && (mode_reg == MODE_IN)));
    assign acc_nold = key_on ? fade_out_len_reg : fade_in_len_reg;

    // after the edge, mode holds the new fade; the old length is the other one
    assign len_nnew = (mode_reg == MODE_IN) ? fade_in_len_reg : fade_out_len_reg;
    assign len_nold = (mode_reg == MODE_IN) ? fade_out_len_reg : fade_in_len_reg;
    assign len_cur  = len_nnew;

    // one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign div_fit   = (rem_shift >= {1'b0, den_reg});
    assign rem_step  = div_fit ? LEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[LEN_W-1:0];
    assign quo_step  = {quo_reg[DIV_W-2:0], div_fit};

    // fold the angle into the first quarter turn
    assign f_val   = quo_reg[ANGLE_BITS-1:0];
    assign f_fold  = ({1'b0, f_val} > ANGLE_HALF);
    assign f_prime = f_fold ? (ANGLE_FULL - {1'b0, f_val}) : {1'b0, f_val};

    // y = angle in Q30, z and Horner terms are products truncated by 2^30
    assign y_val = prod_reg[ANGLE_BITS +: MUL_W];
    assign t_val = prod_reg[30 +: MUL_W];

    // half of (1 - cos), unfolded, then rounded to the gain format
    assign h_raw   = t_val[MUL_W-1:1];
    assign h_clamp = (h_raw > H_ONE) ? H_ONE : h_raw;
    assign h_val   = folded_reg ? (H_ONE - h_clamp) : h_clamp;
    assign h_sum   = (HW'(h_val) << GAIN_FRAC_BITS) + ROUND_HALF;
    assign gain_in = h_sum[30 +: GW];

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_fire)
                begin
                    if (reversal && (acc_nold != '0) && (phase_reg < acc_nold))
                        seq_next = SEQ_RMUL;
                    else
                        seq_next = SEQ_EVAL;
                end
            end
            SEQ_RMUL:  seq_next = SEQ_RLOAD;
            SEQ_RLOAD: seq_next = SEQ_RDIV;
            SEQ_RDIV:
            begin
                if (cnt_reg == DIV_LAST)
                    seq_next = SEQ_REND;
            end
            SEQ_REND:  seq_next = SEQ_EVAL;
            SEQ_EVAL:
            begin
                if (((mode_reg == MODE_IN) || (mode_reg == MODE_OUT)) &&
                    (phase_reg < len_cur))
                    seq_next = SEQ_FDIV;
                else
                    seq_next = SEQ_DONE;
            end
            SEQ_FDIV:
            begin
                if (cnt_reg == DIV_LAST)
                    seq_next = SEQ_YMUL;
            end
            SEQ_YMUL:  seq_next = SEQ_ZMUL;
            SEQ_ZMUL:  seq_next = SEQ_ZSAVE;
            SEQ_ZSAVE: seq_next = SEQ_HMUL;
            SEQ_HMUL:  seq_next = SEQ_HSUB;
            SEQ_HSUB:
            begin
                if (step_reg == HORNER_STEPS)
                    seq_next = SEQ_DONE;
                else
                    seq_next = SEQ_HMUL;
            end
            SEQ_DONE:
            begin
                if (out_free)
                    seq_next = SEQ_IDLE;
            end
            default:   seq_next = SEQ_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath controls and register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        last_key_next   = last_key_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        cnt_next        = cnt_reg;
        folded_next     = folded_reg;
        z_next          = z_reg;
        acc_next        = acc_reg;
        step_next       = step_reg;
        res_gain_next   = res_gain_reg;
        out_valid_next  = out_valid_reg && out_stall;
        gain_next       = gain_reg;
        ramp_state_next = ramp_state_reg;
        mul_a           = '0;
        mul_b           = '0;

        case (seq_reg)
            SEQ_IDLE:
            begin
                // take the key edge; a reversal keeps the phase for remapping
                if (in_fire && key_edge)
                begin
                    last_key_next = key_on;
                    mode_next     = key_on ? MODE_IN : MODE_OUT;
                    if (!(reversal && (acc_nold != '0) && (phase_reg < acc_nold)))
                        phase_next = '0;
                end
            end
            SEQ_RMUL:
            begin
                // Nnew * (Nold - phase)
                mul_a = MUL_W'(len_nnew);
                mul_b = MUL_W'(len_nold - phase_reg);
            end
            SEQ_RLOAD:
            begin
                quo_next = prod_reg[DIV_W-1:0];
                den_next = len_nold;
                rem_next = '0;
                cnt_next = '0;
            end
            SEQ_RDIV, SEQ_FDIV:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
            end
            SEQ_REND:
            begin
                // clamp the remapped phase to the new length
                if ((quo_reg[DIV_W-1:LEN_W] != '0) || (quo_reg[LEN_W-1:0] > len_nnew))
                    phase_next = len_nnew;
                else
                    phase_next = quo_reg[LEN_W-1:0];
            end
            SEQ_EVAL:
            begin
                case (mode_reg)
                    MODE_ON:   res_gain_next = UNITY;
                    MODE_IDLE: res_gain_next = '0;
                    default:
                    begin
                        if (phase_reg >= len_cur)
                        begin
                            // fade over: snap to the end level
                            mode_next     = (mode_reg == MODE_IN) ? MODE_ON : MODE_IDLE;
                            phase_next    = '0;
                            res_gain_next = (mode_reg == MODE_IN) ? UNITY : '0;
                        end
                        else
                        begin
                            // f = phase * 2^ANGLE_BITS / N, then advance the phase
                            quo_next   = DIV_W'({phase_reg, {ANGLE_BITS{1'b0}}});
                            den_next   = len_cur;
                            rem_next   = '0;
                            cnt_next   = '0;
                            phase_next = phase_reg + 1'b1;
                        end
                    end
                endcase
            end
            SEQ_YMUL:
            begin
                folded_next = f_fold;
                mul_a       = MUL_W'(f_prime);
                mul_b       = PI_Q30;
            end
            SEQ_ZMUL:
            begin
                mul_a = y_val;
                mul_b = y_val;
            end
            SEQ_ZSAVE:
            begin
                z_next    = t_val;
                acc_next  = ACC_INIT;
                step_next = '0;
            end
            SEQ_HMUL:
            begin
                mul_a = z_reg;
                mul_b = MUL_W'(acc_reg);
            end
            SEQ_HSUB:
            begin
                if (step_reg == HORNER_STEPS)
                    res_gain_next = (mode_reg == MODE_IN) ? gain_in : (UNITY - gain_in);
                else
                begin
                    acc_next  = horner_sub(step_reg, t_val);
                    step_next = step_reg + 1'b1;
                end
            end
            SEQ_DONE:
            begin
                // hand the beat to the output register once it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    gain_next       = res_gain_reg;
                    ramp_state_next = mode_reg;
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg          <= SEQ_IDLE;
            mode_reg         <= MODE_IDLE;
            phase_reg        <= '0;
            last_key_reg     <= 1'b0;
            fade_in_len_reg  <= LEN_RESET;
            fade_out_len_reg <= LEN_RESET;
            cnt_reg          <= '0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            last_key_reg  <= last_key_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FADE_IN:  fade_in_len_reg  <= cfg_data;
                    CFG_FADE_OUT: fade_out_len_reg <= cfg_data;
                    default:      fade_in_len_reg  <= fade_in_len_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        prod_reg       <= prod_next;
        folded_reg     <= folded_next;
        z_reg          <= z_next;
        acc_reg        <= acc_next;
        res_gain_reg   <= res_gain_next;
        gain_reg       <= gain_next;
        ramp_state_reg <= ramp_state_next;
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `CKEF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat did not start the sequencer")
    `CKEF_ASSERT_NOW(a_gain_range, out_valid, gain <= UNITY, "gain above unity")
    `CKEF_ASSERT_NOW(a_on_unity, out_valid && (ramp_state == MODE_ON), gain == UNITY, "on state without unity gain")
    `CKEF_ASSERT_NOW(a_idle_zero, out_valid && (ramp_state == MODE_IDLE), gain == '0, "idle state with nonzero gain")

endmodule

`default_nettype wire

@@ test/cosine_key_edge_fade_core_tb.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ckef_pkg::*;

    localparam int ANGLE_BITS     = 12;
    localparam int GAIN_FRAC_BITS = 15;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;

    // Random part: ten length settings, a few dozen samples each.
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_BEATS  = 43;
    // Receiver back-pressure: one long hold once this many results have arrived.
    localparam int HOLD_AT      = 150;
    localparam int LONG_HOLD    = 400;
    // Slowest sample is a reversal; leave room for strays.
    localparam int TAIL_CYCLES  = 200;
    localparam int SHOWN_ERRORS = 40;

    localparam logic [63:0] FULL_ANGLE = 64'd1 << ANGLE_BITS;
    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [15:0] UNITY      = 16'd1 << GAIN_FRAC_BITS;

    // Taylor terms of 1-cos in Q30, innermost first
    localparam logic [63:0] TAY_C6 = 64'd2;
    localparam logic [63:0] TAY_C5 = 64'd296;
    localparam logic [63:0] TAY_C4 = 64'd26631;
    localparam logic [63:0] TAY_C3 = 64'd1491308;
    localparam logic [63:0] TAY_C2 = 64'd44739243;
    localparam logic [63:0] TAY_C1 = 64'd536870912;

    typedef struct packed {
        logic [GAIN_FRAC_BITS:0] gain;
        ramp_mode_t              state;
    } fade_beat_t;

    typedef enum logic {ROW_BEAT, ROW_LENGTHS} row_kind_t;

    // One line of the directed plan: either a key sample, with an optional
    // hand-written expectation, or a new pair of fade lengths.
    typedef struct {
        row_kind_t        kind;
        logic             key;
        logic             pinned;
        fade_beat_t       want;
        logic [LEN_W-1:0] in_len;
        logic [LEN_W-1:0] out_len;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    key_on = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [GAIN_FRAC_BITS:0] gain;
    logic [1:0]              ramp_state;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_FADE_IN;
    logic [LEN_W-1:0]        cfg_data = '0;

    // Gain/state beats still owed by the block, oldest first.
    fade_beat_t pending_gain[$];
    plan_row_t  plan[$];

    // Shadow of the ramp: lengths, mode, phase and the last key level.
    logic [LEN_W-1:0] len_in = LEN_RESET;
    logic [LEN_W-1:0] len_out = LEN_RESET;
    ramp_mode_t       ramp_mode = MODE_IDLE;
    logic [LEN_W-1:0] ramp_phase = '0;
    logic             key_prev = 1'b0;

    int  mismatch_count = 0;
    int  result_count = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  hold_done = 1'b0;
    int  rx_hold = 0;

    cosine_key_edge_fade_core #(
        .ANGLE_BITS     (ANGLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_on     (key_on),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .gain       (gain),
        .ramp_state (ramp_state),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard limit: far above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("cosine_key_edge_fade_core regression: fail");
        $finish;
    end

    function automatic logic [63:0] floor_sub(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? (a - b) : 64'd0;
    endfunction

    // Rising half of the raised cosine, 0.5(1-cos(pi*f)), in Q1.15.
    function automatic logic [15:0] cosine_rise(input logic [LEN_W-1:0] phase,
                                                input logic [LEN_W-1:0] n);
        logic [63:0] f;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] acc;
        logic [63:0] h;
        logic        folded;
        f = ({48'd0, phase} << ANGLE_BITS) / {48'd0, n};
        folded = 1'b0;
        // fold the second half onto the first, flip the result back later
        if (f > (FULL_ANGLE >> 1))
        begin
            f = FULL_ANGLE - f;
            folded = 1'b1;
        end
        y = (f * {32'd0, PI_Q30}) >> ANGLE_BITS;
        z = (y * y) >> 30;
        acc = TAY_C6;
        acc = floor_sub(TAY_C5, (z * acc) >> 30);
        acc = floor_sub(TAY_C4, (z * acc) >> 30);
        acc = floor_sub(TAY_C3, (z * acc) >> 30);
        acc = floor_sub(TAY_C2, (z * acc) >> 30);
        acc = floor_sub(TAY_C1, (z * acc) >> 30);
        h = ((z * acc) >> 30) >> 1;
        if (h > Q30_ONE)
            h = Q30_ONE;
        if (folded)
            h = Q30_ONE - h;
        h = ((h << GAIN_FRAC_BITS) + (64'd1 << 29)) >> 30;
        return h[15:0];
    endfunction

    // Phase of the reversed fade that keeps the gain continuous.
    function automatic logic [LEN_W-1:0] carry_phase(input logic [LEN_W-1:0] nold,
                                                     input logic [LEN_W-1:0] nnew,
                                                     input logic [LEN_W-1:0] phase);
        logic [63:0] p;
        if (nold == '0 || phase >= nold)
            return '0;
        p = ({48'd0, nnew} * {48'd0, nold - phase}) / {48'd0, nold};
        if (p > {48'd0, nnew})
            p = {48'd0, nnew};
        return p[LEN_W-1:0];
    endfunction

    // Advance the shadow ramp by one sample and return the beat it yields.
    function automatic fade_beat_t predict_beat(input logic key);
        fade_beat_t b;
        if (key != key_prev)
        begin
            key_prev = key;
            if (key)
            begin
                ramp_phase = (ramp_mode == MODE_OUT) ?
                             carry_phase(len_out, len_in, ramp_phase) : '0;
                ramp_mode = MODE_IN;
            end
            else
            begin
                ramp_phase = (ramp_mode == MODE_IN) ?
                             carry_phase(len_in, len_out, ramp_phase) : '0;
                ramp_mode = MODE_OUT;
            end
        end
        case (ramp_mode)
            MODE_ON:
                b.gain = UNITY;
            MODE_IN:
                if (ramp_phase >= len_in)
                begin
                    ramp_mode = MODE_ON;
                    ramp_phase = '0;
                    b.gain = UNITY;
                end
                else
                begin
                    b.gain = cosine_rise(ramp_phase, len_in);
                    ramp_phase = ramp_phase + 1'b1;
                end
            MODE_OUT:
                if (ramp_phase >= len_out)
                begin
                    ramp_mode = MODE_IDLE;
                    ramp_phase = '0;
                    b.gain = '0;
                end
                else
                begin
                    b.gain = UNITY - cosine_rise(ramp_phase, len_out);
                    ramp_phase = ramp_phase + 1'b1;
                end
            default:
                b.gain = '0;
        endcase
        b.state = ramp_mode;
        return b;
    endfunction

    // Idle cycles before the next beat; each side flips between busy and quiet spells.
    function automatic int idle_cycles(inout bit quiet);
        if ($urandom_range(0, 31) == 0)
            quiet = !quiet;
        return quiet ? 0 : int'($urandom_range(0, 6));
    endfunction

    function automatic plan_row_t key_row(input logic k);
        plan_row_t r;
        r.kind = ROW_BEAT;
        r.key = k;
        r.pinned = 1'b0;
        r.want = '0;
        r.in_len = '0;
        r.out_len = '0;
        return r;
    endfunction

    function automatic plan_row_t pinned_row(input logic k, input logic [15:0] g,
                                             input ramp_mode_t m);
        plan_row_t r;
        r = key_row(k);
        r.pinned = 1'b1;
        r.want.gain = g;
        r.want.state = m;
        return r;
    endfunction

    function automatic plan_row_t len_row(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] b);
        plan_row_t r;
        r = key_row(1'b0);
        r.kind = ROW_LENGTHS;
        r.in_len = a;
        r.out_len = b;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display("MISMATCH result %0d: %s", result_count, what);
    endtask

    // Offer one key sample; valid stays high after the beat so that a
    // back-to-back sample never lowers and raises it in the same step.
    task automatic push_key(input logic k, input logic pinned, input fade_beat_t want);
        int gap;
        fade_beat_t predicted;
        gap = idle_cycles(tx_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        key_on <= k;
        do @(posedge clk); while (in_stall);
        predicted = predict_beat(k);
        pending_gain.push_back(pinned ? want : predicted);
    endtask

    // Drain the block, then write both fade lengths back to back.
    task automatic load_lengths(input logic [LEN_W-1:0] lin, input logic [LEN_W-1:0] lout);
        in_valid <= 1'b0;
        while (pending_gain.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FADE_IN;
        cfg_data <= lin;
        do @(posedge clk); while (!cfg_ready);
        len_in = lin;
        cfg_index <= CFG_FADE_OUT;
        cfg_data <= lout;
        do @(posedge clk); while (!cfg_ready);
        len_out = lout;
        cfg_valid <= 1'b0;
    endtask

    // Result side: check every accepted beat against the oldest expectation,
    // then draw the stall for the next one. Once, hold off for a long stretch
    // so that the core backs up and stalls its input.
    always @(posedge clk)
    begin : rx_side
        fade_beat_t want;
        int g;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (pending_gain.size() == 0)
                    flag_mismatch($sformatf("unexpected beat gain %0d state %0d",
                                            gain, ramp_state));
                else
                begin
                    want = pending_gain.pop_front();
                    if (gain !== want.gain)
                        flag_mismatch($sformatf("gain %0d, want %0d", gain, want.gain));
                    if (ramp_state !== want.state)
                        flag_mismatch($sformatf("ramp_state %0d, want %0d",
                                                ramp_state, want.state));
                end
                g = idle_cycles(rx_quiet);
                if (!hold_done && result_count >= HOLD_AT)
                begin
                    g = LONG_HOLD;
                    hold_done = 1'b1;
                end
                if (g > 0)
                begin
                    out_stall <= 1'b1;
                    rx_hold <= g - 1;
                end
                else
                    out_stall <= 1'b0;
            end
            else if (out_stall)
            begin
                // count down the hold, release when it runs out
                if (rx_hold > 0)
                    rx_hold <= rx_hold - 1;
                else
                    out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int ph;
        int sent;
        int run;
        int cap;
        logic key;
        logic [LEN_W-1:0] lin;
        logic [LEN_W-1:0] lout;

        // Directed plan. Pinned rows are read straight off the ramp rules:
        // out of reset, fade start at phase zero, zero-length snaps, a length
        // cut below the running phase, and a reversal from past the old end.
        plan.push_back(pinned_row(1'b0, 16'd0, MODE_IDLE));
        plan.push_back(pinned_row(1'b1, 16'd0, MODE_IN));
        plan.push_back(key_row(1'b1));
        plan.push_back(key_row(1'b0));                      // reversal, reset lengths
        plan.push_back(len_row(16'd0, 16'd0));
        plan.push_back(pinned_row(1'b1, UNITY, MODE_ON));    // zero fade-in snaps
        plan.push_back(pinned_row(1'b0, 16'd0, MODE_IDLE));  // zero fade-out snaps
        plan.push_back(len_row(16'hFFFF, 16'hFFFF));
        plan.push_back(pinned_row(1'b1, 16'd0, MODE_IN));
        plan.push_back(key_row(1'b0));                      // reversal, longest fades
        plan.push_back(key_row(1'b1));                      // back in, phase at old end
        plan.push_back(len_row(16'd4, 16'd3));
        plan.push_back(key_row(1'b0));
        plan.push_back(key_row(1'b0));
        plan.push_back(key_row(1'b0));
        plan.push_back(key_row(1'b0));
        plan.push_back(key_row(1'b1));
        plan.push_back(key_row(1'b1));
        plan.push_back(key_row(1'b1));
        plan.push_back(len_row(16'd2, 16'd3));               // cut below phase 3
        plan.push_back(pinned_row(1'b1, UNITY, MODE_ON));
        plan.push_back(pinned_row(1'b1, UNITY, MODE_ON));
        plan.push_back(len_row(16'd6, 16'd8));
        plan.push_back(key_row(1'b0));
        plan.push_back(key_row(1'b0));
        plan.push_back(key_row(1'b0));
        plan.push_back(len_row(16'd6, 16'd1));               // fade-out now behind phase
        plan.push_back(pinned_row(1'b1, 16'd0, MODE_IN));
        plan.push_back(key_row(1'b0));
        plan.push_back(key_row(1'b0));
        plan.push_back(key_row(1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_LENGTHS)
                load_lengths(plan[i].in_len, plan[i].out_len);
            else
                push_key(plan[i].key, plan[i].pinned, plan[i].want);
        end

        // Random part: key runs sized to the fade lengths, so that fades
        // complete, snap and get reversed partway. The first two settings
        // pair the extremes; the last one is drawn over the full range.
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    lin = 16'hFFFF;
                    lout = 16'd0;
                end
                1:
                begin
                    lin = 16'd0;
                    lout = 16'hFFFF;
                end
                RAND_PHASES - 1:
                begin
                    lin = LEN_W'($urandom_range(0, 65535));
                    lout = LEN_W'($urandom_range(0, 65535));
                end
                default:
                begin
                    lin = ($urandom_range(0, 7) == 0) ? 16'd0 : LEN_W'($urandom_range(1, 24));
                    lout = ($urandom_range(0, 7) == 0) ? 16'd0 : LEN_W'($urandom_range(1, 24));
                end
            endcase
            load_lengths(lin, lout);
            cap = ((lin > lout) ? int'(lin) : int'(lout)) + 3;
            if (cap > 40)
                cap = 40;
            key = 1'($urandom_range(0, 1));
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                run = $urandom_range(1, cap);
                // trim the last run so each setting sends the same count
                if (run > PHASE_BEATS - sent)
                    run = PHASE_BEATS - sent;
                repeat (run)
                begin
                    push_key(key, 1'b0, '0);
                    sent++;
                end
                key = !key;
            end
        end

        // Drop valid, drain, and give stray beats time to show up.
        in_valid <= 1'b0;
        while (pending_gain.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("cosine_key_edge_fade_core regression: pass");
        else
            $display("cosine_key_edge_fade_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
